// ===== hw/rtl/mprm_pkg.sv =====
`timescale 1ns / 1ps
// mprm_pkg: shared types and constants of the memory pressure restart monitor
// request and result payloads, register map, action and reason codes
// no dependencies
package mprm_pkg;

    // snapshot request payload
    typedef struct packed {
        logic [19:0] used_mb;
        logic [19:0] total_mb;
        logic [63:0] stamp_ms;
        logic [31:0] batch_id;
    } snap_t;

    // result payload
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] use_pct;
        logic [15:0] peak_percent;
        logic [31:0] high_run_count;
        logic [31:0] soft_restart_count;
        logic [31:0] cache_clear_count;
        logic        restart_pending;
        logic [1:0]  restart_cause;
        logic [6:0]  restarts_logged;
    } rslt_t;

    // configuration register values
    typedef struct packed {
        logic [6:0]  threshold_percent;
        logic [15:0] sustained_batches;
        logic [15:0] clear_interval;
        logic [15:0] restart_hours;
        logic [63:0] origin_ms;
    } cfg_t;

    // per-request values handed to the decision logic
    typedef struct packed {
        logic [15:0] pct;
        logic        high;
        logic [63:0] stamp;
        logic [31:0] batch;
        logic [37:0] limit;
    } item_t;

    // action codes
    localparam logic [1:0] ACT_CONTINUE   = 2'd0;
    localparam logic [1:0] ACT_CLEAR      = 2'd1;
    localparam logic [1:0] ACT_RESTART    = 2'd2;
    localparam logic [1:0] ACT_CHECKPOINT = 2'd3;

    // pending restart reasons
    localparam logic [1:0] RSN_NONE      = 2'd0;
    localparam logic [1:0] RSN_PRESSURE  = 2'd1;
    localparam logic [1:0] RSN_SCHEDULED = 2'd2;

    // register indexes (8-byte spacing)
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SUSTAINED = 3'd1;
    localparam logic [2:0] REG_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_HOURS     = 3'd3;
    localparam logic [2:0] REG_START     = 3'd4;

    // register reset values
    localparam logic [6:0]  THRESHOLD_RST = 7'd85;
    localparam logic [15:0] SUSTAINED_RST = 16'd50;
    localparam logic [15:0] INTERVAL_RST  = 16'd100;
    localparam logic [15:0] HOURS_RST     = 16'd168;

    // arithmetic constants
    localparam logic [6:0]  PERCENT_SCALE = 7'd100;
    localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
    localparam int          DIV_QBITS     = 16;
    localparam int          DIV_CNT_W     = $clog2(DIV_QBITS + 1);

endpackage

// ===== hw/rtl/memory_pressure_restart_monitor.sv =====
`timescale 1ns / 1ps
// memory_pressure_restart_monitor: request sequencer around the percent divider
// depends on mprm_pkg, mprm_cfg, mprm_div, mprm_policy
//
// Usage:
// - snap channel (snap_valid / snap_stall / snap_data) takes one memory
//   snapshot request; rslt channel (rslt_valid / rslt_stall / rslt_data)
//   returns exactly one result per request.
// - the apb port holds the settings at byte addresses 0, 8, 16, 24, 32;
//   write them only while no request is in flight.
// - rslt_valid rises once the percent divider has produced its 16 quotient
//   bits, one bit per cycle, and the result is loaded; when total memory is
//   zero or the percent saturates, the divide iterations are skipped.
// - snap_stall stays high from acceptance until the result is loaded into
//   the output register; the next request may then be taken while that
//   result still waits, so no new request is taken before the last
//   result is loaded.
// - when the receiver stalls, the result holds in the output register; a
//   following request finishes its divide and then waits until the
//   register frees before it updates any kept state.
// - reset clears all counters, the peak, the pending restart and restores
//   the default settings; no request is in flight after reset.
module memory_pressure_restart_monitor #(
    parameter int LOG_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready,
    input  logic            snap_valid,
    output logic            snap_stall,
    input  mprm_pkg::snap_t snap_data,
    output logic            rslt_valid,
    input  logic            rslt_stall,
    output mprm_pkg::rslt_t rslt_data
);
    import mprm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DECIDE
    } state_t;

    state_t      state_reg;
    logic        rslt_valid_reg;
    rslt_t       rslt_reg;
    snap_t       snap_reg;
    logic [26:0] used100_reg;
    logic        high_reg;
    logic [37:0] limit_reg;

    cfg_t        cfg;
    item_t       item;
    rslt_t       rslt_new;
    logic        accept;
    logic        out_free;
    logic        commit;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_quo;
    logic [26:0] thr_total;

    assign accept     = snap_valid && !snap_stall;
    assign snap_stall = (state_reg != S_IDLE);
    assign out_free   = !rslt_valid_reg || !rslt_stall;
    assign commit     = (state_reg == S_DECIDE) && out_free;
    assign div_start  = (state_reg == S_PREP);
    assign thr_total  = 27'(cfg.threshold_percent) * 27'(snap_reg.total_mb);
    assign rslt_valid = rslt_valid_reg;
    assign rslt_data  = rslt_reg;

    // settings
    mprm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // percent = used * 25600 / total
    mprm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({used100_reg, 8'h00}),
        .divisor  (snap_reg.total_mb),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign item.pct   = div_quo;
    assign item.high  = high_reg;
    assign item.stamp = snap_reg.stamp_ms;
    assign item.batch = snap_reg.batch_id;
    assign item.limit = limit_reg;

    mprm_policy #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_policy (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .cfg    (cfg),
        .item   (item),
        .rslt   (rslt_new)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rslt_valid_reg <= 1'b0;
            rslt_reg       <= '0;
        end
        else
        begin
            // load on commit, free once taken
            if (commit)
            begin
                rslt_reg       <= rslt_new;
                rslt_valid_reg <= 1'b1;
            end
            else if (rslt_valid_reg && !rslt_stall)
            begin
                rslt_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // request datapath: capture, high test, schedule limit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snap_reg    <= snap_data;
            used100_reg <= 27'(snap_data.used_mb) * 27'(PERCENT_SCALE);
        end
        if (state_reg == S_PREP)
        begin
            // never high with zero total memory
            high_reg <= (snap_reg.total_mb != 20'd0) && (used100_reg > thr_total);
        end
        if (state_reg == S_DIV)
        begin
            limit_reg <= 38'(cfg.restart_hours) * 38'(MS_PER_HOUR);
        end
    end

endmodule

// ===== hw/rtl/mprm_cfg.sv =====
`timescale 1ns / 1ps
// mprm_cfg: apb register file holding the five monitor settings
// depends on mprm_pkg
module mprm_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output mprm_pkg::cfg_t    cfg
);
    import mprm_pkg::*;

    logic [2:0] idx;
    logic       wr_en;
    cfg_t       cfg_reg;

    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_percent <= THRESHOLD_RST;
            cfg_reg.sustained_batches <= SUSTAINED_RST;
            cfg_reg.clear_interval    <= INTERVAL_RST;
            cfg_reg.restart_hours     <= HOURS_RST;
            cfg_reg.origin_ms         <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_THRESHOLD: cfg_reg.threshold_percent <= pwdata[6:0];
                REG_SUSTAINED: cfg_reg.sustained_batches <= pwdata[15:0];
                REG_INTERVAL:  cfg_reg.clear_interval    <= pwdata[15:0];
                REG_HOURS:     cfg_reg.restart_hours     <= pwdata[15:0];
                REG_START:     cfg_reg.origin_ms         <= pwdata;
                default:       ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_THRESHOLD: prdata = 64'(cfg_reg.threshold_percent);
            REG_SUSTAINED: prdata = 64'(cfg_reg.sustained_batches);
            REG_INTERVAL:  prdata = 64'(cfg_reg.clear_interval);
            REG_HOURS:     prdata = 64'(cfg_reg.restart_hours);
            REG_START:     prdata = cfg_reg.origin_ms;
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/mprm_div.sv =====
`timescale 1ns / 1ps
// mprm_div: restoring divider, one quotient bit per cycle
// gives a 16-bit saturated quotient, zero for a zero divisor; depends on mprm_pkg
module mprm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [34:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import mprm_pkg::*;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    dstate_t              dstate_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [19:0]          rem_reg;
    logic [15:0]          quo_reg;
    logic [21:0]          diff;
    logic                 overflow;

    // trial subtract of the shifted remainder
    assign diff     = {1'b0, rem_reg, quo_reg[15]} - {2'b00, divisor};
    // quotient would not fit in 16 bits
    assign overflow = {1'b0, dividend} >= {divisor, 16'h0000};

    assign done     = done_reg;
    assign quotient = quo_reg;

    // sequencing of the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (dstate_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (divisor == 20'd0 || overflow)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg    <= DIV_CNT_W'(DIV_QBITS);
                            dstate_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(1))
                    begin
                        done_reg   <= 1'b1;
                        dstate_reg <= D_IDLE;
                    end
                end
                default: dstate_reg <= D_IDLE;
            endcase
        end
    end

    // remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (dstate_reg == D_IDLE && start)
        begin
            if (divisor == 20'd0)
            begin
                quo_reg <= '0;
            end
            else if (overflow)
            begin
                quo_reg <= '1;
            end
            else
            begin
                rem_reg <= {1'b0, dividend[34:16]};
                quo_reg <= dividend[15:0];
            end
        end
        else if (dstate_reg == D_RUN)
        begin
            if (!diff[21])
            begin
                rem_reg <= diff[19:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[18:0], quo_reg[15]};
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/mprm_policy.sv =====
`timescale 1ns / 1ps
// mprm_policy: action choice and the kept counters, peak and pending restart
// state moves on commit; result is the value after this request; depends on mprm_pkg
module mprm_policy #(
    parameter int LOG_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  mprm_pkg::cfg_t  cfg,
    input  mprm_pkg::item_t item,
    output mprm_pkg::rslt_t rslt
);
    import mprm_pkg::*;

    localparam int            LW      = $clog2(LOG_DEPTH + 1);
    localparam logic [LW-1:0] LOG_MAX = LW'(LOG_DEPTH);

    logic [31:0]   high_run_reg, high_run_next;
    logic [15:0]   peak_reg, peak_next;
    logic [31:0]   last_clear_reg, last_clear_next;
    logic [31:0]   clears_reg, clears_next;
    logic [31:0]   restarts_reg, restarts_next;
    logic          flag_reg, flag_next;
    logic [1:0]    reason_reg, reason_next;
    logic [LW-1:0] logged_reg, logged_next;

    logic [31:0]   run_inc;
    logic [63:0]   elapsed;
    logic [31:0]   clr_gap;
    logic          sched;
    logic          sustain;
    logic          clr;
    logic [LW-1:0] logged_inc;
    logic [LW+6:0] logged_ext;
    logic [1:0]    act;

    // decision and next state
    always_comb
    begin
        peak_next  = (item.pct > peak_reg) ? item.pct : peak_reg;
        run_inc    = (high_run_reg == '1) ? high_run_reg : high_run_reg + 32'd1;
        elapsed    = item.stamp - cfg.origin_ms;
        clr_gap    = item.batch - last_clear_reg;
        logged_inc = (logged_reg < LOG_MAX) ? logged_reg + LW'(1) : logged_reg;

        high_run_next   = item.high ? run_inc : '0;
        last_clear_next = last_clear_reg;
        clears_next     = clears_reg;
        restarts_next   = restarts_reg;
        flag_next       = flag_reg;
        reason_next     = reason_reg;
        logged_next     = logged_reg;
        act             = ACT_CONTINUE;

        sched   = (cfg.origin_ms != 64'd0) && (item.stamp != 64'd0)
                  && (elapsed >= 64'(item.limit));
        sustain = high_run_next >= 32'(cfg.sustained_batches);
        clr     = (item.batch != 32'd0)
                  && ((item.batch < last_clear_reg) || (clr_gap >= 32'(cfg.clear_interval)));

        if (sched)
        begin
            flag_next   = 1'b1;
            reason_next = RSN_SCHEDULED;
            logged_next = logged_inc;
            act         = ACT_CHECKPOINT;
        end
        else if (sustain)
        begin
            flag_next     = 1'b1;
            reason_next   = RSN_PRESSURE;
            logged_next   = logged_inc;
            high_run_next = '0;
            restarts_next = (restarts_reg == '1) ? restarts_reg : restarts_reg + 32'd1;
            act           = ACT_RESTART;
        end
        else if (clr)
        begin
            last_clear_next = item.batch;
            clears_next     = (clears_reg == '1) ? clears_reg : clears_reg + 32'd1;
            act             = ACT_CLEAR;
        end

        logged_ext = (LW + 7)'(logged_next);

        rslt.action             = act;
        rslt.use_pct            = item.pct;
        rslt.peak_percent       = peak_next;
        rslt.high_run_count     = high_run_next;
        rslt.soft_restart_count = restarts_next;
        rslt.cache_clear_count  = clears_next;
        rslt.restart_pending    = flag_next;
        rslt.restart_cause      = reason_next;
        rslt.restarts_logged    = logged_ext[6:0];
    end

    // kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_run_reg   <= '0;
            peak_reg       <= '0;
            last_clear_reg <= '0;
            clears_reg     <= '0;
            restarts_reg   <= '0;
            flag_reg       <= 1'b0;
            reason_reg     <= RSN_NONE;
            logged_reg     <= '0;
        end
        else if (commit)
        begin
            high_run_reg   <= high_run_next;
            peak_reg       <= peak_next;
            last_clear_reg <= last_clear_next;
            clears_reg     <= clears_next;
            restarts_reg   <= restarts_next;
            flag_reg       <= flag_next;
            reason_reg     <= reason_next;
            logged_reg     <= logged_next;
        end
    end

endmodule

// ===== hw/rtl/mprm_chk.sv =====
`timescale 1ns / 1ps
// mprm_chk: port-level checks of the monitor, bound to the top level
// depends on mprm_pkg and memory_pressure_restart_monitor
module mprm_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            snap_valid,
    input logic            snap_stall,
    input logic            rslt_valid,
    input logic            rslt_stall,
    input mprm_pkg::rslt_t rslt_data
);
    import mprm_pkg::*;

    // busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid && !snap_stall) |=> snap_stall)
        else $error("request accepted on two consecutive cycles");

    // stalled result holds
    a_rslt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rslt_valid && rslt_stall) |=> (rslt_valid && $stable(rslt_data)))
        else $error("stalled result changed or dropped");

    // peak never below the current percent
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid |-> (rslt_data.peak_percent >= rslt_data.use_pct))
        else $error("peak below current percent");

    // pending flag and reason agree
    a_reason: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid |-> (rslt_data.restart_pending == (rslt_data.restart_cause != RSN_NONE)))
        else $error("pending flag and reason disagree");

    // soft restart clears the high run
    a_restart_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rslt_valid && rslt_data.action == ACT_RESTART) |-> (rslt_data.high_run_count == 32'd0))
        else $error("high run not cleared on soft restart");

endmodule

bind memory_pressure_restart_monitor mprm_chk u_mprm_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .rslt_valid (rslt_valid),
    .rslt_stall (rslt_stall),
    .rslt_data  (rslt_data)
);
